// ===== hdl/tmm_pkg.sv =====
// Shared constants for the 8x8 outer-product matrix-multiply tile.
`timescale 1ns / 1ps
`default_nettype none

package tmm_pkg;

  // Lanes per tile row (columns j..j+7)
  localparam int LANES = 8;

  // Operand, product and result widths (Q2.14 in, Q4.28 products, Q20.28 out)
  localparam int A_W    = 16;
  localparam int PROD_W = 2 * A_W;
  localparam int SUM_W  = 48;
  localparam int ROW_W  = 3;

  // Default sizing of the accumulator store
  localparam int DEF_TILE_ROWS = 8;
  localparam int DEF_ACC_BITS  = 48;

endpackage

`default_nettype wire

// ===== hdl/tile_matmul_outer_product_8x8_unit.sv =====
// Output-stationary 8x8 matrix-multiply tile: top level.
//
// Input channel (in_valid / in_ready): one A element, its tile row, eight B
// elements and the first_k / last_k marks of the k sweep. The A element is
// multiplied into all eight lanes; first_k loads the row's accumulators with
// the products, otherwise the products are added (wrapping, ACC_BITS wide).
// Items whose tile row is not below TILE_ROWS are taken and dropped.
// Result channel (out_valid / out_ready): on last_k the row's eight sums,
// sign-extended or cut to 48 bits, with the row number.
// Path: the products and the accumulator row read are registered when the
// item is transferred; the add and write-back load the output register as
// the add stage advances. Throughput: one item per cycle while in_ready is
// high; the accumulator memory is read and written once per in-range item,
// and a back-to-back update of the same row is forwarded.
// When the receiver stalls, the output register holds its result and items
// without last_k keep flowing; a second last_k item waits in the add stage,
// and in_ready drops until out_ready frees the output register.
// Reset clears only the valid and forwarding flags; the accumulator
// memory is not cleared, and a row must be started with first_k before use.
`timescale 1ns / 1ps
`default_nettype none

module tile_matmul_outer_product_8x8_unit
  import tmm_pkg::*;
#(
  parameter int TILE_ROWS = DEF_TILE_ROWS,
  parameter int ACC_BITS  = DEF_ACC_BITS
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic signed [A_W-1:0]   in_a_value,
  input  wire logic        [ROW_W-1:0] in_tile_row,
  input  wire logic signed [A_W-1:0]   in_b_lane_0,
  input  wire logic signed [A_W-1:0]   in_b_lane_1,
  input  wire logic signed [A_W-1:0]   in_b_lane_2,
  input  wire logic signed [A_W-1:0]   in_b_lane_3,
  input  wire logic signed [A_W-1:0]   in_b_lane_4,
  input  wire logic signed [A_W-1:0]   in_b_lane_5,
  input  wire logic signed [A_W-1:0]   in_b_lane_6,
  input  wire logic signed [A_W-1:0]   in_b_lane_7,
  input  wire logic                    in_first_k,
  input  wire logic                    in_last_k,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic        [ROW_W-1:0]      out_row,
  output logic signed [SUM_W-1:0]      out_sum_lane_0,
  output logic signed [SUM_W-1:0]      out_sum_lane_1,
  output logic signed [SUM_W-1:0]      out_sum_lane_2,
  output logic signed [SUM_W-1:0]      out_sum_lane_3,
  output logic signed [SUM_W-1:0]      out_sum_lane_4,
  output logic signed [SUM_W-1:0]      out_sum_lane_5,
  output logic signed [SUM_W-1:0]      out_sum_lane_6,
  output logic signed [SUM_W-1:0]      out_sum_lane_7
);

  localparam int RowAw = (TILE_ROWS > 1) ? $clog2(TILE_ROWS) : 1;
  localparam int RowDw = LANES * ACC_BITS;

  // Input lanes as an array
  logic signed [A_W-1:0] b_in [LANES];
  assign b_in[0] = in_b_lane_0;
  assign b_in[1] = in_b_lane_1;
  assign b_in[2] = in_b_lane_2;
  assign b_in[3] = in_b_lane_3;
  assign b_in[4] = in_b_lane_4;
  assign b_in[5] = in_b_lane_5;
  assign b_in[6] = in_b_lane_6;
  assign b_in[7] = in_b_lane_7;

  // Add-stage registers
  logic                     s1_valid_r;
  logic [ROW_W-1:0]         s1_row_r;
  logic                     s1_first_r;
  logic                     s1_last_r;
  logic signed [PROD_W-1:0] s1_prod_r [LANES];
  logic signed [PROD_W-1:0] prod_nxt  [LANES];

  // Forwarding of a same-row write that coincided with the read
  logic             byp_hit_r;
  logic [RowDw-1:0] byp_data_r;

  // Output register
  logic                    out_valid_r;
  logic [ROW_W-1:0]        out_row_r;
  logic signed [SUM_W-1:0] out_sum_r [LANES];

  logic                       in_fire;
  logic                       row_ok;
  logic                       s1_adv;
  logic                       out_load;
  logic                       byp_hit_nxt;
  logic [RowDw-1:0]           rd_data;
  logic [RowDw-1:0]           base_row;
  logic [RowDw-1:0]           sum_row;
  logic signed [ACC_BITS-1:0] sum_lane [LANES];

  // Handshake and stage advance
  assign row_ok   = {1'b0, in_tile_row} < (ROW_W + 1)'(TILE_ROWS);
  assign s1_adv   = !s1_last_r || !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_fire  = in_valid && in_ready;
  assign out_load = s1_valid_r && s1_last_r && s1_adv;

  // Multiply A into every lane
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      prod_nxt[l] = in_a_value * b_in[l];
    end
  end

  // Accumulator row store
  tmm_row_mem #(
    .TILE_ROWS (TILE_ROWS),
    .ACC_BITS  (ACC_BITS)
  ) u_row_mem (
    .clk     (clk),
    .rd_en   (in_fire && row_ok),
    .rd_addr (in_tile_row[RowAw-1:0]),
    .rd_data (rd_data),
    .wr_en   (s1_valid_r && s1_adv),
    .wr_addr (s1_row_r[RowAw-1:0]),
    .wr_data (sum_row)
  );

  // Pick the freshest row contents, then add the products
  assign base_row = byp_hit_r ? byp_data_r : rd_data;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (s1_first_r) begin
        sum_lane[l] = ACC_BITS'(s1_prod_r[l]);
      end else begin
        sum_lane[l] = base_row[l*ACC_BITS +: ACC_BITS] + ACC_BITS'(s1_prod_r[l]);
      end
      sum_row[l*ACC_BITS +: ACC_BITS] = sum_lane[l];
    end
  end

  // Same-row write at the read edge means the memory returns stale data
  assign byp_hit_nxt = s1_valid_r && s1_adv && (s1_row_r == in_tile_row);

  // Advance the add stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      byp_hit_r  <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= row_ok;
      byp_hit_r  <= byp_hit_nxt;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  // Payload of the add stage
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_row_r   <= in_tile_row;
      s1_first_r <= in_first_k;
      s1_last_r  <= in_last_k;
      byp_data_r <= sum_row;
      for (int l = 0; l < LANES; l++) begin
        s1_prod_r[l] <= prod_nxt[l];
      end
    end
  end

  // Hold the result until transferred
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_row_r <= s1_row_r;
      for (int l = 0; l < LANES; l++) begin
        out_sum_r[l] <= SUM_W'(sum_lane[l]);
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_row        = out_row_r;
  assign out_sum_lane_0 = out_sum_r[0];
  assign out_sum_lane_1 = out_sum_r[1];
  assign out_sum_lane_2 = out_sum_r[2];
  assign out_sum_lane_3 = out_sum_r[3];
  assign out_sum_lane_4 = out_sum_r[4];
  assign out_sum_lane_5 = out_sum_r[5];
  assign out_sum_lane_6 = out_sum_r[6];
  assign out_sum_lane_7 = out_sum_r[7];

`ifndef SYNTH
  // The add stage only waits behind a full output register with a row to emit
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |-> (s1_last_r && out_valid_r && !out_ready))
    else $error("add stage stalled without a pending result");

  // Input is refused only while a finished row waits in the add stage
  a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && s1_last_r && out_valid_r))
    else $error("input refused with no result backed up");

  // A row leaving the add stage with last_k is presented next cycle
  a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_valid && (out_row == $past(s1_row_r))))
    else $error("finished row not presented");

  // Forwarding is armed only by a write that coincided with the read
  a_byp_source: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && byp_hit_nxt) |-> (s1_valid_r && s1_adv))
    else $error("forwarding armed without a write-back");
`endif

endmodule

`default_nettype wire

// ===== hdl/tmm_row_mem.sv =====
// Accumulator row store: one write port, one read port, registered read data.
`timescale 1ns / 1ps
`default_nettype none

module tmm_row_mem
  import tmm_pkg::*;
#(
  parameter int TILE_ROWS = DEF_TILE_ROWS,
  parameter int ACC_BITS  = DEF_ACC_BITS
) (
  input  wire logic                                                clk,
  input  wire logic                                                rd_en,
  input  wire logic [((TILE_ROWS > 1) ? $clog2(TILE_ROWS) : 1)-1:0] rd_addr,
  output logic      [LANES*ACC_BITS-1:0]                           rd_data,
  input  wire logic                                                wr_en,
  input  wire logic [((TILE_ROWS > 1) ? $clog2(TILE_ROWS) : 1)-1:0] wr_addr,
  input  wire logic [LANES*ACC_BITS-1:0]                           wr_data
);

  logic [LANES*ACC_BITS-1:0] mem [TILE_ROWS];

  // Write the updated row
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read one row into the rd_data register (old data on a same-row write)
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire
